### hw/rtl/lpg_pkg.sv
// Shared constants, the quarter-wave sine table and the sine lookup for the
// Lissajous point generator. Depends on nothing; used by lissajous_point_generator.
package lpg_pkg;

    localparam int PHASE_BITS = 24;
    localparam int SINE_DEPTH = 256;
    localparam int COORD_BITS = 10;

    localparam int REG_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int COUNT_W    = 16;
    localparam int SCREEN_W   = 10;
    localparam int COORD_W    = 10;
    localparam int SINE_W     = 16;
    localparam int U_W        = SINE_W + 1;
    localparam int PROD_W     = SCREEN_W + U_W;

    localparam int FRAC_BITS  = PHASE_BITS - 2;
    localparam int TAB_BITS   = $clog2(SINE_DEPTH);
    localparam int UP_SHIFT   = (PHASE_BITS >= REG_W) ? PHASE_BITS - REG_W : 0;
    localparam int DN_SHIFT   = (PHASE_BITS < REG_W) ? REG_W - PHASE_BITS : 0;
    localparam int COORD_KEEP = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_KEEP) - 64'd1);

    localparam logic [U_W-1:0] U_MID = U_W'(32768);
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Reciprocals of the Taylor divisors (2n)(2n+1), exact for dividends below 2^33.
    localparam int TAYLOR_SHIFT [7] = '{36, 38, 39, 40, 40, 41, 41};
    localparam longint unsigned TAYLOR_RECIP [7] = '{
        ((64'd1 << 36) + 64'd5)   / 64'd6,
        ((64'd1 << 38) + 64'd19)  / 64'd20,
        ((64'd1 << 39) + 64'd41)  / 64'd42,
        ((64'd1 << 40) + 64'd71)  / 64'd72,
        ((64'd1 << 40) + 64'd109) / 64'd110,
        ((64'd1 << 41) + 64'd155) / 64'd156,
        ((64'd1 << 41) + 64'd209) / 64'd210
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP_X   = 3'd0,
        CFG_PHASE_STEP_Y   = 3'd1,
        CFG_PHASE_OFFSET_X = 3'd2,
        CFG_POINT_COUNT    = 3'd3,
        CFG_SCREEN_COLS    = 3'd4,
        CFG_SCREEN_ROWS    = 3'd5
    } cfg_index_t;

    typedef logic [SINE_W-1:0] sine_tab_t [SINE_DEPTH];

    // Each entry is a Q30 Taylor series of the sine at the bin center, rounded to Q15.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        logic [127:0]    prod;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            x = (PI_Q30 * longint'(2 * k + 1)) >> (TAB_BITS + 2);
            term = x;
            sum = x;
            for (int n = 1; n <= 7; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                prod = 128'(term) * 128'(TAYLOR_RECIP[n-1]);
                term = 64'(prod >> TAYLOR_SHIFT[n-1]);
                if ((n & 1) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            sum = (sum + 64'd16384) >> 15;
            if (sum > 64'd32768) begin
                sum = 64'd32768;
            end
            tab[k] = SINE_W'(sum);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    // Returns the sine offset by one half scale, in the range 0 to 65536.
    function automatic logic [U_W-1:0] sine_u(input logic [PHASE_BITS-1:0] phase);
        logic [1:0]                    quad;
        logic [FRAC_BITS-1:0]          frac;
        logic [FRAC_BITS+TAB_BITS-1:0] scaled;
        logic [TAB_BITS-1:0]           idx;
        logic [SINE_W-1:0]             v;
        quad   = phase[PHASE_BITS-1 -: 2];
        frac   = phase[FRAC_BITS-1:0];
        scaled = (FRAC_BITS+TAB_BITS)'(frac) << TAB_BITS;
        idx    = TAB_BITS'(scaled >> FRAC_BITS);
        if (quad[0]) begin
            idx = ~idx;
        end
        v = SINE_TAB[idx];
        return quad[1] ? (U_MID - U_W'(v)) : (U_MID + U_W'(v));
    endfunction

    // Converts a 24-bit register value to a phase of PHASE_BITS bits.
    function automatic logic [PHASE_BITS-1:0] to_phase(input logic [REG_W-1:0] r);
        logic [PHASE_BITS+REG_W-1:0] wide;
        wide = ((PHASE_BITS+REG_W)'(r) << UP_SHIFT) >> DN_SHIFT;
        return wide[PHASE_BITS-1:0];
    endfunction

endpackage

### hw/rtl/lissajous_point_generator.sv
// Lissajous point generator: phase accumulators, sine lookup and screen scaling.
// Depends on lpg_pkg for constants, the sine table and the lookup functions.
//
// Each accepted transaction on the s_ channel yields exactly one point on the m_ channel.
// A new transaction is taken every clock while the m_ channel is not stalled; the phase
// accumulators and the point counter update in the accept cycle, which is what sets this
// one-point-per-clock rate. A point reaches the m_ channel through a chain of registers:
// one holds the phases, one the table lookups, and one the scaled and clamped coordinates.
// Setting s_start_req restarts the curve at t = 0; m_last marks the final point of each
// period, after which the curve restarts by itself. Configuration writes through
// cfg_wr_en take effect from the next accepted transaction and should be made while no
// point is in flight.
module lissajous_point_generator
    import lpg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_start_req,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COORD_W-1:0]   m_x_coord,
    output logic [COORD_W-1:0]   m_y_coord,
    output logic                 m_last
);

    logic [REG_W-1:0]      phase_step_x_reg;
    logic [REG_W-1:0]      phase_step_y_reg;
    logic [REG_W-1:0]      phase_offset_x_reg;
    logic [COUNT_W-1:0]    point_count_reg;
    logic [SCREEN_W-1:0]   screen_cols_reg;
    logic [SCREEN_W-1:0]   screen_rows_reg;

    logic [PHASE_BITS-1:0] phase_acc_x_reg, phase_acc_x_next;
    logic [PHASE_BITS-1:0] phase_acc_y_reg, phase_acc_y_next;
    logic [COUNT_W-1:0]    point_index_reg, point_index_next;

    logic                  s1_valid_reg;
    logic [PHASE_BITS-1:0] s1_phase_x_reg, s1_phase_x_next;
    logic [PHASE_BITS-1:0] s1_phase_y_reg, s1_phase_y_next;
    logic                  s1_last_reg, s1_last_next;

    logic                  s2_valid_reg;
    logic [U_W-1:0]        s2_ux_reg, s2_ux_next;
    logic [U_W-1:0]        s2_uy_reg, s2_uy_next;
    logic                  s2_last_reg;

    logic                  m_valid_reg;
    logic [COORD_W-1:0]    m_x_coord_reg, m_x_coord_next;
    logic [COORD_W-1:0]    m_y_coord_reg, m_y_coord_next;
    logic                  m_last_reg;

    logic                  out_ready;
    logic                  s2_ready;
    logic                  s_fire;

    logic [PHASE_BITS-1:0] acc_x_cur;
    logic [PHASE_BITS-1:0] acc_y_cur;
    logic [COUNT_W-1:0]    index_cur;

    logic [PROD_W-1:0]     x_prod;
    logic [PROD_W-1:0]     y_prod;
    logic [SCREEN_W:0]     x_raw;
    logic [SCREEN_W:0]     y_raw;
    logic [SCREEN_W-1:0]   cols_m1;
    logic [SCREEN_W-1:0]   rows_m1;
    logic [SCREEN_W-1:0]   x_val;
    logic [SCREEN_W-1:0]   y_val;

    assign out_ready = !m_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s_ready   = !s1_valid_reg || s2_ready;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_x_reg   <= '0;
            phase_step_y_reg   <= '0;
            phase_offset_x_reg <= '0;
            point_count_reg    <= COUNT_W'(1);
            screen_cols_reg    <= SCREEN_W'(80);
            screen_rows_reg    <= SCREEN_W'(24);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_PHASE_STEP_X:   phase_step_x_reg   <= cfg_wdata;
                CFG_PHASE_STEP_Y:   phase_step_y_reg   <= cfg_wdata;
                CFG_PHASE_OFFSET_X: phase_offset_x_reg <= cfg_wdata;
                CFG_POINT_COUNT:    point_count_reg    <= cfg_wdata[COUNT_W-1:0];
                CFG_SCREEN_COLS:    screen_cols_reg    <= cfg_wdata[SCREEN_W-1:0];
                CFG_SCREEN_ROWS:    screen_rows_reg    <= cfg_wdata[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    // A start request zeroes the state before the point is formed.
    always_comb begin
        acc_x_cur = s_start_req ? '0 : phase_acc_x_reg;
        acc_y_cur = s_start_req ? '0 : phase_acc_y_reg;
        index_cur = s_start_req ? '0 : point_index_reg;

        s1_phase_x_next = acc_x_cur + to_phase(phase_offset_x_reg);
        s1_phase_y_next = acc_y_cur;
        s1_last_next    = (index_cur >= point_count_reg);

        if (s1_last_next) begin
            phase_acc_x_next = '0;
            phase_acc_y_next = '0;
            point_index_next = '0;
        end else begin
            phase_acc_x_next = acc_x_cur + to_phase(phase_step_x_reg);
            phase_acc_y_next = acc_y_cur + to_phase(phase_step_y_reg);
            point_index_next = index_cur + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_x_reg <= '0;
            phase_acc_y_reg <= '0;
            point_index_reg <= '0;
            s1_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_acc_x_reg <= phase_acc_x_next;
                phase_acc_y_reg <= phase_acc_y_next;
                point_index_reg <= point_index_next;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_phase_x_reg <= s1_phase_x_next;
            s1_phase_y_reg <= s1_phase_y_next;
            s1_last_reg    <= s1_last_next;
        end
    end

    assign s2_ux_next = sine_u(s1_phase_x_reg);
    assign s2_uy_next = sine_u(s1_phase_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_ux_reg   <= s2_ux_next;
            s2_uy_reg   <= s2_uy_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Scale to the screen and clamp points that land one past the edge.
    always_comb begin
        cols_m1 = screen_cols_reg - SCREEN_W'(1);
        rows_m1 = screen_rows_reg - SCREEN_W'(1);
        x_prod  = PROD_W'(screen_cols_reg) * PROD_W'(s2_ux_reg);
        y_prod  = PROD_W'(rows_m1) * PROD_W'(s2_uy_reg);
        x_raw   = x_prod[PROD_W-1 -: SCREEN_W+1];
        y_raw   = y_prod[PROD_W-1 -: SCREEN_W+1] + (SCREEN_W+1)'(1);

        if (screen_cols_reg == '0) begin
            x_val = '0;
        end else if (x_raw > (SCREEN_W+1)'(cols_m1)) begin
            x_val = cols_m1;
        end else begin
            x_val = x_raw[SCREEN_W-1:0];
        end

        if (screen_rows_reg < SCREEN_W'(2)) begin
            y_val = SCREEN_W'(1);
        end else if (y_raw > (SCREEN_W+1)'(rows_m1)) begin
            y_val = rows_m1;
        end else begin
            y_val = y_raw[SCREEN_W-1:0];
        end

        m_x_coord_next = COORD_W'(x_val) & COORD_MASK;
        m_y_coord_next = COORD_W'(y_val) & COORD_MASK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s2_valid_reg) begin
            m_x_coord_reg <= m_x_coord_next;
            m_y_coord_reg <= m_y_coord_next;
            m_last_reg    <= s2_last_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_x_coord = m_x_coord_reg;
    assign m_y_coord = m_y_coord_reg;
    assign m_last    = m_last_reg;

    // The curve restarts after the last point of a period.
    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s1_last_next |=> point_index_reg == '0 && phase_acc_x_reg == '0 &&
                                   phase_acc_y_reg == '0)
        else $error("state not cleared after last point");

    // After a start request the counter has advanced by at most one point.
    a_start_index: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_start_req |=> point_index_reg <= COUNT_W'(1))
        else $error("start request did not reset the point counter");

    // The input side stalls only when every stage holds a point.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg && s2_valid_reg && m_valid_reg)
        else $error("input stalled with a pipeline bubble");

    // Row zero is reserved, so a delivered point never lands on it.
    a_row_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_y_coord != '0)
        else $error("point placed on reserved row zero");

endmodule
